/* sv/assert_macros.svh */
// assertion macros shared by the unfilter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* sv/pngunf_pkg.sv */
// types and constants of the png scanline unfilter
`default_nettype none
package pngunf_pkg;

    localparam int BYTE_W = 8;
    localparam int BPP_W  = 3;
    localparam int ROWB_W = 9;
    localparam int CFG_W  = 9;

    // configuration register indexes
    localparam logic [0:0] CFG_BPP       = 1'b0;
    localparam logic [0:0] CFG_ROW_BYTES = 1'b1;

    localparam logic [BPP_W-1:0]  BPP_RESET  = 3'd1;
    localparam logic [ROWB_W-1:0] ROWB_RESET = 9'd384;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } t_filter;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              new_image;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel_byte;
        logic              row_end;
        logic              bad_filter;
    } t_out_item;

    // one window cell: left byte and upper-left byte
    typedef struct packed {
        logic [BYTE_W-1:0] left;
        logic [BYTE_W-1:0] ul;
    } t_win;

    typedef struct packed {
        logic shift;
        logic clr;
    } t_win_ctl;

endpackage
`default_nettype wire

/* sv/pngunf_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module pngunf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 384
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* sv/pngunf_cell.sv */
// one cell of the left / upper-left byte window chain
`default_nettype none
module pngunf_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pngunf_pkg::t_win_ctl i_ctl,
    input  wire pngunf_pkg::t_win     i_win,
    output      pngunf_pkg::t_win     o_win
);

    pngunf_pkg::t_win r_win;
    pngunf_pkg::t_win n_win;

    always_comb begin
        n_win = r_win;
        if (i_ctl.clr) begin
            n_win = '0;
        end else if (i_ctl.shift) begin
            n_win = i_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else begin
            r_win <= n_win;
        end
    end

    assign o_win = r_win;

endmodule
`default_nettype wire

/* sv/pngunf_pred.sv */
// filter predictor and byte reconstruction
`default_nettype none
module pngunf_pred (
    input  wire pngunf_pkg::t_filter               i_kind,
    input  wire logic [pngunf_pkg::BYTE_W-1:0]     i_raw,
    input  wire logic [pngunf_pkg::BYTE_W-1:0]     i_a,
    input  wire logic [pngunf_pkg::BYTE_W-1:0]     i_b,
    input  wire logic [pngunf_pkg::BYTE_W-1:0]     i_c,
    output      logic [pngunf_pkg::BYTE_W-1:0]     o_value
);

    logic signed [9:0] sa, sb, sc;
    logic signed [9:0] d_bc, d_ac, d_abc;
    logic [9:0] m_a, m_b, m_c;
    logic [pngunf_pkg::BYTE_W-1:0] paeth, avg, pred;

    always_comb begin
        sa = signed'({2'b00, i_a});
        sb = signed'({2'b00, i_b});
        sc = signed'({2'b00, i_c});
        // distances of p = a + b - c to a, b and c
        d_bc  = sb - sc;
        d_ac  = sa - sc;
        d_abc = sa + sb - sc - sc;
        m_a = (d_bc  < 0) ? 10'(-d_bc)  : 10'(d_bc);
        m_b = (d_ac  < 0) ? 10'(-d_ac)  : 10'(d_ac);
        m_c = (d_abc < 0) ? 10'(-d_abc) : 10'(d_abc);
        if (m_a <= m_b && m_a <= m_c) begin
            paeth = i_a;
        end else if (m_b <= m_c) begin
            paeth = i_b;
        end else begin
            paeth = i_c;
        end
        avg = 8'((9'(i_a) + 9'(i_b)) >> 1);
        case (i_kind)
            pngunf_pkg::FLT_NONE:  pred = '0;
            pngunf_pkg::FLT_SUB:   pred = i_a;
            pngunf_pkg::FLT_UP:    pred = i_b;
            pngunf_pkg::FLT_AVG:   pred = avg;
            pngunf_pkg::FLT_PAETH: pred = paeth;
            default:               pred = '0;
        endcase
        o_value = i_raw + pred;
    end

endmodule
`default_nettype wire

/* sv/png_scanline_unfilter_core.sv */
// png scanline unfilter top level: row state, window chain, previous-row memory
// the result of an accepted input transaction is in the output register in the next cycle
// throughput: one byte per cycle while the result stream is not stalled; the previous-row ram is read one byte ahead
// reset: synchronous active low; clears row, error and window state, registers to 1 / 384
// the previous-row memory is not cleared; the first row of an image never reads it
`default_nettype none
`include "assert_macros.svh"
module png_scanline_unfilter_core #(
    parameter int MAX_ROW_BYTES   = 384,
    parameter int MAX_PIXEL_BYTES = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input byte stream
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire pngunf_pkg::t_in_item           i_in,
    // result stream
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      pngunf_pkg::t_out_item          o_out,
    // configuration writes
    input  wire logic                           i_cfg_we,
    input  wire logic [0:0]                     i_cfg_idx,
    input  wire logic [pngunf_pkg::CFG_W-1:0]   i_cfg_data
);

    // column counter holds 0..row length, ram address 0..row length - 1
    localparam int CW = $clog2(MAX_ROW_BYTES + 1);
    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int PW = $clog2(MAX_PIXEL_BYTES + 1);
    localparam int LW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    // clamp the row length register into 1..MAX_ROW_BYTES
    function automatic logic [CW-1:0] clamp_rb(input logic [pngunf_pkg::ROWB_W-1:0] v);
        if (v == '0) begin
            return CW'(1);
        end else if (32'(v) > MAX_ROW_BYTES) begin
            return CW'(MAX_ROW_BYTES);
        end else begin
            return CW'(v);
        end
    endfunction

    // clamp bytes per pixel into 1..MAX_PIXEL_BYTES
    function automatic logic [PW-1:0] clamp_bpp(input logic [pngunf_pkg::BPP_W-1:0] v);
        if (v == '0) begin
            return PW'(1);
        end else if (32'(v) > MAX_PIXEL_BYTES) begin
            return PW'(MAX_PIXEL_BYTES);
        end else begin
            return PW'(v);
        end
    endfunction

    // configuration registers
    logic [pngunf_pkg::BPP_W-1:0]  r_bpp,       n_bpp;
    logic [pngunf_pkg::ROWB_W-1:0] r_row_bytes, n_row_bytes;

    // row state
    logic [CW-1:0]          r_column,    n_column;
    pngunf_pkg::t_filter    r_kind,      n_kind;
    logic                   r_first_row, n_first_row;
    logic                   r_halted,    n_halted;

    // output register
    logic                   r_out_valid, n_out_valid;
    pngunf_pkg::t_out_item  r_out,       n_out;

    // datapath
    logic                   acc, nw, is_filter, is_data, bad, last, has_left, emit;
    logic [CW-1:0]          eff_rb, col_m1, x_c;
    logic [PW-1:0]          eff_bpp;
    logic [LW-1:0]          tap;
    logic [AW-1:0]          x_addr, rd_addr;
    logic [CW-1:0]          n_eff_rb, n_col_m1, rd_c;
    logic [pngunf_pkg::BYTE_W-1:0] rd_q, a_byte, b_byte, c_byte, value;
    pngunf_pkg::t_win       w_win [MAX_PIXEL_BYTES];
    pngunf_pkg::t_win_ctl   win_ctl;

    // a transaction is taken whenever the output register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign acc        = i_in_valid && o_in_ready;
    assign nw         = i_in.new_image;

    // new_image clears state first; the byte is then a filter byte
    assign is_filter = nw || (!r_halted && r_column == '0);
    assign is_data   = !nw && !r_halted && r_column != '0;
    assign bad       = i_in.data_byte > 8'(pngunf_pkg::FLT_PAETH);

    // current data index, held inside the row
    assign eff_rb  = clamp_rb(r_row_bytes);
    assign eff_bpp = clamp_bpp(r_bpp);
    assign col_m1  = r_column - CW'(1);
    assign x_c     = (col_m1 >= eff_rb) ? (eff_rb - CW'(1)) : col_m1;
    assign x_addr  = AW'(x_c);
    assign last    = (x_c == eff_rb - CW'(1));

    // left neighbors only exist past the first pixel
    assign has_left = 32'(x_c) >= 32'(eff_bpp);
    assign tap      = LW'(eff_bpp - PW'(1));
    assign a_byte   = has_left ? w_win[tap].left : '0;
    assign b_byte   = r_first_row ? '0 : rd_q;
    assign c_byte   = (!r_first_row && has_left) ? w_win[tap].ul : '0;

    pngunf_pred u_pred (
        .i_kind  (r_kind),
        .i_raw   (i_in.data_byte),
        .i_a     (a_byte),
        .i_b     (b_byte),
        .i_c     (c_byte),
        .o_value (value)
    );

    // window chain: cell 0 takes the new byte and its up byte
    assign win_ctl.clr   = acc && is_filter;
    assign win_ctl.shift = acc && is_data;

    for (genvar k = 0; k < MAX_PIXEL_BYTES; k++) begin : g_cell
        pngunf_pkg::t_win cell_in;
        if (k == 0) begin : g_head
            assign cell_in = '{left: value, ul: b_byte};
        end else begin : g_link
            assign cell_in = w_win[k-1];
        end
        pngunf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (win_ctl),
            .i_win   (cell_in),
            .o_win   (w_win[k])
        );
    end

    // next-state logic
    always_comb begin
        n_bpp       = r_bpp;
        n_row_bytes = r_row_bytes;
        n_column    = r_column;
        n_kind      = r_kind;
        n_first_row = r_first_row;
        n_halted    = r_halted;
        emit        = 1'b0;

        if (i_cfg_we && i_cfg_idx == pngunf_pkg::CFG_BPP) begin
            n_bpp = i_cfg_data[pngunf_pkg::BPP_W-1:0];
        end
        if (i_cfg_we && i_cfg_idx == pngunf_pkg::CFG_ROW_BYTES) begin
            n_row_bytes = i_cfg_data[pngunf_pkg::ROWB_W-1:0];
        end

        if (acc) begin
            if (nw) begin
                n_column    = '0;
                n_kind      = pngunf_pkg::FLT_NONE;
                n_first_row = 1'b1;
                n_halted    = 1'b0;
            end
            if (is_filter) begin
                if (bad) begin
                    // error transaction, then drop bytes until new_image
                    n_halted = 1'b1;
                    emit     = 1'b1;
                end else begin
                    n_kind   = pngunf_pkg::t_filter'(i_in.data_byte[2:0]);
                    n_column = CW'(1);
                end
            end else if (is_data) begin
                emit = 1'b1;
                if (last) begin
                    n_column    = '0;
                    n_first_row = 1'b0;
                end else begin
                    n_column = r_column + CW'(1);
                end
            end
        end

        // output register loads a result or drains
        n_out = r_out;
        if (emit) begin
            n_out_valid = 1'b1;
            if (is_data) begin
                n_out = '{pixel_byte: value, row_end: last, bad_filter: 1'b0};
            end else begin
                n_out = '{pixel_byte: '0, row_end: 1'b0, bad_filter: 1'b1};
            end
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
        end
    end

    // read address for the next data byte, from next state so ram data lines up
    assign n_eff_rb = clamp_rb(n_row_bytes);
    assign n_col_m1 = n_column - CW'(1);
    assign rd_c     = (n_column == '0) ? '0 :
                      (n_col_m1 >= n_eff_rb) ? (n_eff_rb - CW'(1)) : n_col_m1;
    assign rd_addr  = AW'(rd_c);

    // previous-row store; written as each data byte is rebuilt
    pngunf_ram #(
        .WIDTH (pngunf_pkg::BYTE_W),
        .DEPTH (MAX_ROW_BYTES)
    ) u_prev_row (
        .i_clk   (i_clk),
        .i_we    (acc && is_data),
        .i_waddr (x_addr),
        .i_wdata (value),
        .i_raddr (rd_addr),
        .o_rdata (rd_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp       <= pngunf_pkg::BPP_RESET;
            r_row_bytes <= pngunf_pkg::ROWB_RESET;
            r_column    <= '0;
            r_kind      <= pngunf_pkg::FLT_NONE;
            r_first_row <= 1'b1;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_bpp       <= n_bpp;
            r_row_bytes <= n_row_bytes;
            r_column    <= n_column;
            r_kind      <= n_kind;
            r_first_row <= n_first_row;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // halted only ever waits on a filter byte position
    `ASSERT_IMPL(a_halt_col, r_halted, r_column == '0, "halted with a row in progress")
    // a bad filter byte leaves an error result and the halted flag
    `ASSERT_NEXT(a_err_halts, acc && is_filter && bad,
        r_halted && r_out_valid && r_out.bad_filter, "bad filter not reported")
    // a stalled result blocks new input
    `ASSERT_IMPL(a_stall_block, r_out_valid && !i_out_ready, !o_in_ready,
        "input taken over a stalled result")
    // every filter byte starts the row with an empty window
    `ASSERT_NEXT(a_filter_clears, acc && is_filter, w_win[0] == '0,
        "window not cleared at row start")

endmodule
`default_nettype wire

/* verif/png_scanline_unfilter_core_tb.sv */
// self-checking testbench for the png scanline unfilter core
`timescale 1ns / 100ps
module png_scanline_unfilter_core_tb;

    localparam int MAX_ROWB        = 384;
    localparam int MAX_PIX         = 4;
    localparam int RANDOM_ITEMS    = 550;
    localparam int SETTLE_CYCLES   = 4;      // quiet time after the last owed result, with margin
    localparam int LIMIT_CYCLES    = 500000;
    localparam logic [7:0] BAD_FLT_MIN = 8'(pngunf_pkg::FLT_PAETH) + 8'd1;

    typedef enum bit [1:0] {ROW_CFG, ROW_ITEM, ROW_PIN} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [0:0]            idx;
        logic [8:0]            val;
        pngunf_pkg::t_in_item  it;
        pngunf_pkg::t_out_item want;
    } t_dir_row;

    // what one accepted byte transaction should produce
    typedef struct {
        bit                    has;
        pngunf_pkg::t_out_item val;
    } t_rebuild;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    pngunf_pkg::t_in_item  i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    pngunf_pkg::t_out_item o_out;
    logic                  i_cfg_we;
    logic [0:0]            i_cfg_idx;
    logic [pngunf_pkg::CFG_W-1:0] i_cfg_data;

    png_scanline_unfilter_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // unfilter state as the testbench sees it
    logic [pngunf_pkg::BPP_W-1:0]  bpp_reg;
    logic [pngunf_pkg::ROWB_W-1:0] rowb_reg;
    int unsigned       col;
    pngunf_pkg::t_filter flt;
    bit                on_first_row;
    bit                halted;
    logic [7:0]        prev_row [MAX_ROWB];
    logic [7:0]        left_win [MAX_PIX];
    logic [7:0]        ul_win   [MAX_PIX];

    t_rebuild  staged_bytes [$];   // presented, not yet accepted
    pngunf_pkg::t_out_item want_bytes [$];     // accepted, result still owed

    bit gaps_on, stall_on, noise_on, force_new;
    int n_err, n_checked, n_bad, n_cfg, n_directed, n_random, longest_row;
    int cycles;
    int ready_left;

    always #4 i_clk = ~i_clk;

    function automatic int unsigned row_len(input logic [pngunf_pkg::ROWB_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_ROWB) return MAX_ROWB;
        return v;
    endfunction

    function automatic void clear_rows();
        col = 0;
        flt = pngunf_pkg::FLT_NONE;
        on_first_row = 1'b1;
        halted = 1'b0;
        foreach (left_win[k]) begin
            left_win[k] = '0;
            ul_win[k] = '0;
        end
    endfunction

    // rebuild one byte; returns 1 when the transaction yields a result
    function automatic bit rebuild_byte(input pngunf_pkg::t_in_item it,
                                        output pngunf_pkg::t_out_item res);
        int unsigned bpp, rb, x;
        int a, b, c, p, da, db, dc, pred;
        logic [7:0] value;
        bit last;
        res = '0;
        if (it.new_image) clear_rows();
        if (halted) return 1'b0;
        bpp = (bpp_reg == 0) ? 1 : (bpp_reg > MAX_PIX) ? MAX_PIX : bpp_reg;
        rb = row_len(rowb_reg);
        if (col == 0) begin
            if (it.data_byte > 8'(pngunf_pkg::FLT_PAETH)) begin
                halted = 1'b1;
                res.bad_filter = 1'b1;
                return 1'b1;
            end
            flt = pngunf_pkg::t_filter'(it.data_byte[2:0]);
            col = 1;
            foreach (left_win[k]) begin
                left_win[k] = '0;
                ul_win[k] = '0;
            end
            return 1'b0;
        end
        // a shrunk row length ends the row on the current byte
        x = col - 1;
        if (x >= rb) x = rb - 1;
        a = (x >= bpp) ? int'(left_win[bpp-1]) : 0;
        b = on_first_row ? 0 : int'(prev_row[x]);
        c = (!on_first_row && x >= bpp) ? int'(ul_win[bpp-1]) : 0;
        case (flt)
            pngunf_pkg::FLT_SUB:   pred = a;
            pngunf_pkg::FLT_UP:    pred = b;
            pngunf_pkg::FLT_AVG:   pred = (a + b) / 2;
            pngunf_pkg::FLT_PAETH: begin
                p  = a + b - c;
                da = (p > a) ? p - a : a - p;
                db = (p > b) ? p - b : b - p;
                dc = (p > c) ? p - c : c - p;
                if (da <= db && da <= dc) pred = a;
                else if (db <= dc)        pred = b;
                else                      pred = c;
            end
            default:   pred = 0;
        endcase
        value = 8'(int'(it.data_byte) + pred);
        for (int k = MAX_PIX - 1; k > 0; k--) begin
            left_win[k] = left_win[k-1];
            ul_win[k] = ul_win[k-1];
        end
        left_win[0] = value;
        ul_win[0] = 8'(b);
        prev_row[x] = value;
        last = (x + 1 >= rb);
        if (last) begin
            col = 0;
            on_first_row = 1'b0;
        end else begin
            col = x + 2;
        end
        res.pixel_byte = value;
        res.row_end = last;
        return 1'b1;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_dir_row d_cfg(input logic [0:0] idx, input logic [8:0] val);
        t_dir_row r;
        r = '{ROW_CFG, idx, val, '0, '0};
        return r;
    endfunction

    function automatic t_dir_row d_item(input logic [7:0] byt, input bit ni);
        t_dir_row r;
        r = '{ROW_ITEM, 1'b0, 9'd0, '{byt, ni}, '0};
        return r;
    endfunction

    function automatic t_dir_row d_pin(input logic [7:0] byt, input bit ni,
                                       input logic [7:0] pix, input bit re, input bit bad);
        t_dir_row r;
        r = '{ROW_PIN, 1'b0, 9'd0, '{byt, ni}, '{pix, re, bad}};
        return r;
    endfunction

    // present one byte and hold it until the core takes it
    task automatic push_byte(input pngunf_pkg::t_in_item it, input bit pinned,
                             input pngunf_pkg::t_out_item pin_val);
        t_rebuild rb;
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        rb.has = rebuild_byte(it, rb.val);
        if (pinned) begin
            rb.has = 1'b1;
            rb.val = pin_val;
        end
        if (it.new_image) force_new = 1'b0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        staged_bytes.push_back(rb);
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending, wait for every owed result, then let the pipeline go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (staged_bytes.size() != 0 || want_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [8:0] val);
        int unsigned old_len;
        old_len = row_len(rowb_reg);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_cfg++;
        if (idx == pngunf_pkg::CFG_BPP) begin
            bpp_reg = val[pngunf_pkg::BPP_W-1:0];
        end else begin
            rowb_reg = val[pngunf_pkg::ROWB_W-1:0];
            if (row_len(rowb_reg) > longest_row) longest_row = row_len(rowb_reg);
            // a longer row would read unwritten previous-row entries: start a new image
            if (row_len(rowb_reg) > old_len && !on_first_row) force_new = 1'b1;
        end
    endtask

    // result checking and acceptance tracking
    always @(posedge i_clk) begin : score
        pngunf_pkg::t_out_item w;
        t_rebuild  rb;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (want_bytes.size() == 0) begin
                    $display("%0t: result with nothing owed, got %0h/%0b/%0b", $time,
                             o_out.pixel_byte, o_out.row_end, o_out.bad_filter);
                    n_err++;
                end else begin
                    w = want_bytes.pop_front();
                    n_checked++;
                    if (w.bad_filter) n_bad++;
                    if (o_out.pixel_byte !== w.pixel_byte) begin
                        $display("%0t: pixel_byte expected %0h actual %0h", $time,
                                 w.pixel_byte, o_out.pixel_byte);
                        n_err++;
                    end
                    if (o_out.row_end !== w.row_end) begin
                        $display("%0t: row_end expected %0b actual %0b", $time,
                                 w.row_end, o_out.row_end);
                        n_err++;
                    end
                    if (o_out.bad_filter !== w.bad_filter) begin
                        $display("%0t: bad_filter expected %0b actual %0b", $time,
                                 w.bad_filter, o_out.bad_filter);
                        n_err++;
                    end
                end
            end
            if (i_in_valid && o_in_ready && staged_bytes.size() != 0) begin
                rb = staged_bytes.pop_front();
                if (rb.has) want_bytes.push_back(rb.val);
            end
        end
    end

    // receiver pacing
    always @(posedge i_clk) begin : out_pace
        int unsigned roll;
        if (ready_left > 0) begin
            ready_left--;
        end else if (!stall_on) begin
            i_out_ready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                i_out_ready <= 1'b1;
                ready_left = $urandom_range(0, 7);
            end else if (roll < 95) begin
                i_out_ready <= 1'b0;
                ready_left = $urandom_range(0, 2);
            end else begin
                i_out_ready <= 1'b0;
                ready_left = $urandom_range(8, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results owed", $time, want_bytes.size());
            $display("png_scanline_unfilter_core_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row dir_tab [$];
        pngunf_pkg::t_in_item it;
        int unsigned roll, len;
        int phase;
        bit big;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        bpp_reg = pngunf_pkg::BPP_RESET;
        rowb_reg = pngunf_pkg::ROWB_RESET;
        foreach (prev_row[k]) prev_row[k] = '0;
        clear_rows();
        gaps_on = 1'b1;
        stall_on = 1'b1;
        noise_on = 1'b1;
        force_new = 1'b0;
        longest_row = 0;

        // two-byte rows through every filter, then a bad filter type,
        // then four-byte pixels and register values outside their range
        dir_tab = '{
            d_cfg(pngunf_pkg::CFG_ROW_BYTES, 9'd2),
            d_cfg(pngunf_pkg::CFG_BPP, 9'd1),
            d_item(8'(pngunf_pkg::FLT_NONE), 1'b1),
            d_pin(8'h00, 1'b0, 8'h00, 1'b0, 1'b0),
            d_pin(8'hff, 1'b0, 8'hff, 1'b1, 1'b0),
            d_item(8'(pngunf_pkg::FLT_SUB), 1'b0),
            d_item(8'h01, 1'b0),
            d_item(8'hff, 1'b0),
            d_item(8'(pngunf_pkg::FLT_UP), 1'b0),
            d_item(8'h80, 1'b0),
            d_item(8'h7f, 1'b0),
            d_item(8'(pngunf_pkg::FLT_AVG), 1'b0),
            d_item(8'hff, 1'b0),
            d_item(8'hff, 1'b0),
            d_item(8'(pngunf_pkg::FLT_PAETH), 1'b0),
            d_item(8'h12, 1'b0),
            d_item(8'hed, 1'b0),
            d_pin(BAD_FLT_MIN, 1'b0, 8'h00, 1'b0, 1'b1),
            // dropped while halted
            d_item(8'(pngunf_pkg::FLT_PAETH), 1'b0),
            d_item(8'hff, 1'b0),
            d_cfg(pngunf_pkg::CFG_BPP, 9'd4),
            d_cfg(pngunf_pkg::CFG_ROW_BYTES, 9'd5),
            d_item(8'(pngunf_pkg::FLT_SUB), 1'b1),
            d_pin(8'hab, 1'b0, 8'hab, 1'b0, 1'b0),
            d_pin(8'hcd, 1'b0, 8'hcd, 1'b0, 1'b0),
            d_pin(8'hef, 1'b0, 8'hef, 1'b0, 1'b0),
            // row length cut to zero mid-row: the next byte closes the row
            d_cfg(pngunf_pkg::CFG_ROW_BYTES, 9'd0),
            d_cfg(pngunf_pkg::CFG_BPP, 9'd7),
            d_pin(8'h34, 1'b0, 8'h34, 1'b1, 1'b0),
            d_cfg(pngunf_pkg::CFG_BPP, 9'd0)
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                settle();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end else begin
                push_byte(dir_tab[i].it, dir_tab[i].kind == ROW_PIN, dir_tab[i].want);
                n_directed++;
            end
        end

        // random phases: well-formed images with random content and a little noise,
        // one phase runs full-length rows
        phase = 0;
        while (n_random < RANDOM_ITEMS) begin
            settle();
            big = (phase == 2);
            gaps_on = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            noise_on = !big;
            if (big) begin
                write_reg(pngunf_pkg::CFG_BPP, 9'd4);
                write_reg(pngunf_pkg::CFG_ROW_BYTES, 9'd511);
                force_new = 1'b1;
                len = 1 + MAX_ROWB + 1 + 20;
            end else begin
                if (phase == 0 || $urandom_range(0, 1) != 0)
                    write_reg(pngunf_pkg::CFG_BPP, 9'($urandom_range(0, 7)));
                if (phase == 0 || $urandom_range(0, 1) != 0) begin
                    roll = $urandom_range(0, 99);
                    write_reg(pngunf_pkg::CFG_ROW_BYTES,
                              (roll < 70) ? 9'($urandom_range(1, 8)) :
                              (roll < 90) ? 9'($urandom_range(9, 40)) :
                              (roll < 95) ? 9'd0 : 9'($urandom_range(385, 511)));
                end
                len = $urandom_range(15, 60);
            end
            repeat (len) begin
                it.new_image = force_new || (noise_on && $urandom_range(0, 99) < 2) ||
                               (halted && $urandom_range(0, 3) != 0);
                if (col == 0 || it.new_image || halted) begin
                    it.data_byte = (noise_on && $urandom_range(0, 99) < 5) ?
                                   8'($urandom_range(BAD_FLT_MIN, 255)) :
                                   8'($urandom_range(0, 4));
                end else begin
                    // extra weight on corner values to provoke paeth ties
                    roll = $urandom_range(0, 99);
                    it.data_byte = (roll < 4)  ? 8'h00 :
                                   (roll < 8)  ? 8'hff :
                                   (roll < 12) ? 8'h80 :
                                   (roll < 15) ? 8'h01 : 8'($urandom_range(0, 255));
                end
                if (!(halted && !it.new_image)) n_random++;
                push_byte(it, 1'b0, '0);
            end
            phase++;
        end

        settle();
        $display("covered %0d directed and %0d random byte transactions over %0d phases",
                 n_directed, n_random, phase);
        $display("%0d results checked (%0d bad filter), %0d register writes, rows up to %0d",
                 n_checked, n_bad, n_cfg, longest_row);
        if (n_err == 0)
            $display("png_scanline_unfilter_core_tb: PASS");
        else
            $display("png_scanline_unfilter_core_tb: FAIL");
        $finish;
    end

endmodule
